/* rtl/fpr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_pkg: shared types for the FIFO page replacement block
// Request and result payloads, the control word of the sequencer, its
// program, and the control/status bundles between sequencer and datapath.
// ----------------------------------------------------------------------------
package fpr_pkg;

    localparam int unsigned PAGE_W      = 16;
    localparam int unsigned COUNT_W     = 16;
    localparam int unsigned FCOUNT_W    = 5;
    localparam int unsigned DEF_MAX_FRAMES = 16;
    localparam logic [FCOUNT_W-1:0] FCOUNT_RESET = FCOUNT_W'(4);

    // one page reference
    typedef struct packed {
        logic [PAGE_W-1:0] page_number;
        logic              restart;
    } t_req;

    // one result
    typedef struct packed {
        logic               fault;
        logic [COUNT_W-1:0] fault_count;
    } t_rsp;

    // program steps
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SETUP  = 2'd1,
        ST_SCAN   = 2'd2,
        ST_UPDATE = 2'd3
    } t_step;

    // jump conditions: jump to target when met, else stay on this step
    typedef enum logic [1:0] {
        C_START     = 2'd0,
        C_SCAN_LAST = 2'd1,
        C_ALWAYS    = 2'd2
    } t_cond;

    // control word
    typedef struct packed {
        t_cond cond;
        t_step target;
        logic  load;
        logic  setup;
        logic  scan;
        logic  update;
    } t_word;

    // decoded control to the datapath
    typedef struct packed {
        logic load;     // request accepted this cycle
        logic setup;
        logic scan;
        logic update;
    } t_ctrl;

    // status back to the sequencer
    typedef struct packed {
        logic scan_last;
    } t_stat;

    // program ROM
    function automatic t_word fpr_rom(input t_step step);
        t_word w;
        w = '{cond: C_ALWAYS, target: ST_IDLE, load: 1'b0, setup: 1'b0,
              scan: 1'b0, update: 1'b0};
        unique case (step)
            ST_IDLE: begin
                w.cond   = C_START;
                w.target = ST_SETUP;
                w.load   = 1'b1;
            end
            ST_SETUP: begin
                w.cond   = C_ALWAYS;
                w.target = ST_SCAN;
                w.setup  = 1'b1;
            end
            ST_SCAN: begin
                w.cond   = C_SCAN_LAST;
                w.target = ST_UPDATE;
                w.scan   = 1'b1;
            end
            ST_UPDATE: begin
                w.cond   = C_ALWAYS;
                w.target = ST_IDLE;
                w.update = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

/* rtl/fifo_page_replacement.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_page_replacement: FIFO page replacement simulator
// Searches the frames in use for each page reference, loads misses into a
// free frame or the oldest one, and reports the fault and running count.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. With n frames in use
// (frame_count, zero read as one, capped at MAX_FRAMES) the block scans one
// frame per cycle through a frame memory with one write port and a registered
// read port, and busy stays high through the setup, scan and update steps of
// the microcode sequencer. The result is presented on o_rsp with o_done high for
// exactly one cycle, in the cycle that busy falls, and cannot be held off;
// the next request may be started in that same cycle. A request with restart
// set clears all frames, the oldest pointer and the fault count first.
// frame_count may be written only while busy is low.
// ----------------------------------------------------------------------------
module fifo_page_replacement
    import fpr_pkg::*;
#(
    parameter int unsigned MAX_FRAMES = DEF_MAX_FRAMES
)(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  t_req                i_req,
    output logic                busy,
    input  logic                i_cfg_we,
    input  logic [FCOUNT_W-1:0] i_cfg_data,
    output logic                o_done,
    output t_rsp                o_rsp
);

    t_ctrl ctrl;
    t_stat stat;

    // sequencer
    fpr_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .o_busy  (busy)
    );

    // datapath
    fpr_datapath #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ctrl),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_stat     (stat),
        .o_done     (o_done),
        .o_rsp      (o_rsp)
    );

endmodule

/* rtl/fpr_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_seq: microcode sequencer
// Step counter over the program ROM; each step's word drives the datapath
// and picks between holding the step and jumping to its target.
// ----------------------------------------------------------------------------
module fpr_seq
    import fpr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_ctrl o_ctrl,
    output logic  o_busy
);

    t_step r_step;
    t_step n_step;
    t_word word;
    logic  cond_met;

    assign word = fpr_rom(r_step);

    // jump condition
    always_comb begin
        unique case (word.cond)
            C_START:     cond_met = i_start;
            C_SCAN_LAST: cond_met = i_stat.scan_last;
            C_ALWAYS:    cond_met = 1'b1;
            default:     cond_met = 1'b0;
        endcase
    end

    // next step
    always_comb begin
        n_step = cond_met ? word.target : r_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // control outputs
    always_comb begin
        o_ctrl.load   = word.load & i_start;
        o_ctrl.setup  = word.setup;
        o_ctrl.scan   = word.scan;
        o_ctrl.update = word.update;
        o_busy        = (r_step != ST_IDLE);
    end

endmodule

/* rtl/fpr_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_datapath: frame store, scan and replacement datapath
// Holds the frame pages (memory), valid bits, oldest pointer and fault
// count. Scans one frame per cycle under sequencer control.
// ----------------------------------------------------------------------------
module fpr_datapath
    import fpr_pkg::*;
#(
    parameter int unsigned MAX_FRAMES = DEF_MAX_FRAMES
)(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ctrl               i_ctrl,
    input  t_req                i_req,
    input  logic                i_cfg_we,
    input  logic [FCOUNT_W-1:0] i_cfg_data,
    output t_stat               o_stat,
    output logic                o_done,
    output t_rsp                o_rsp
);

    localparam int unsigned IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int unsigned CMP_W = (CNT_W > FCOUNT_W) ? CNT_W : FCOUNT_W;

    logic [FCOUNT_W-1:0] r_fcount;
    logic [PAGE_W-1:0]   r_page;
    logic [PAGE_W-1:0]   r_pages [MAX_FRAMES];
    logic [PAGE_W-1:0]   r_rd_page;
    logic [MAX_FRAMES-1:0] r_valid;
    logic [IDX_W-1:0]    r_ptr;
    logic [IDX_W-1:0]    r_idx;
    logic [IDX_W-1:0]    r_slot;
    logic [CNT_W-1:0]    r_n;
    logic [COUNT_W-1:0]  r_total;
    logic                r_hit;
    logic                r_free;
    logic                r_done;
    t_rsp                r_rsp;

    logic [CMP_W-1:0]    fc_ext;
    logic [CMP_W-1:0]    eff_ext;
    logic [CNT_W-1:0]    eff_n;
    logic                scan_last;
    logic [IDX_W-1:0]    rd_addr;
    logic [IDX_W-1:0]    victim;
    logic [IDX_W-1:0]    ptr_inc;
    logic [COUNT_W-1:0]  n_total;
    logic                cur_valid;

    // effective frame count: zero acts as one, clamp to MAX_FRAMES
    always_comb begin
        fc_ext = CMP_W'(r_fcount);
        if (fc_ext == '0) begin
            eff_ext = CMP_W'(1);
        end else if (fc_ext > CMP_W'(MAX_FRAMES)) begin
            eff_ext = CMP_W'(MAX_FRAMES);
        end else begin
            eff_ext = fc_ext;
        end
        eff_n = eff_ext[CNT_W-1:0];
    end

    // scan position and read address of the next frame
    assign cur_valid = r_valid[r_idx];
    assign scan_last = (CNT_W'(r_idx) == (r_n - CNT_W'(1)));
    always_comb begin
        if (i_ctrl.setup || scan_last) begin
            rd_addr = '0;
        end else begin
            rd_addr = r_idx + IDX_W'(1);
        end
    end
    assign o_stat.scan_last = scan_last;

    // replacement target and next pointer
    assign victim  = r_free ? r_slot : r_ptr;
    assign ptr_inc = (CNT_W'(r_ptr) + CNT_W'(1) == r_n) ? '0 : r_ptr + IDX_W'(1);
    assign n_total = (r_total == '1) ? r_total : r_total + COUNT_W'(1);

    // frame page memory: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_ctrl.update && !r_hit) begin
            r_pages[victim] <= r_page;
        end
        r_rd_page <= r_pages[rd_addr];
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcount <= FCOUNT_RESET;
        end else if (i_cfg_we) begin
            r_fcount <= i_cfg_data;
        end
    end

    // request latch
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_page <= i_req.page_number;
        end
    end

    // control state: valid bits, pointer, count, scan flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ptr   <= '0;
            r_total <= '0;
            r_idx   <= '0;
            r_slot  <= '0;
            r_n     <= CNT_W'(1);
            r_hit   <= 1'b0;
            r_free  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.load && i_req.restart) begin
                r_valid <= '0;
                r_ptr   <= '0;
                r_total <= '0;
            end
            if (i_ctrl.setup) begin
                r_n    <= eff_n;
                r_idx  <= '0;
                r_slot <= '0;
                r_hit  <= 1'b0;
                r_free <= 1'b0;
                if (CNT_W'(r_ptr) >= eff_n) begin
                    r_ptr <= '0;
                end
            end
            if (i_ctrl.scan) begin
                if (cur_valid) begin
                    if (r_rd_page == r_page) begin
                        r_hit <= 1'b1;
                    end
                end else if (!r_free) begin
                    r_free <= 1'b1;
                    r_slot <= r_idx;
                end
                if (!scan_last) begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
            if (i_ctrl.update) begin
                r_done <= 1'b1;
                if (!r_hit) begin
                    r_valid[victim] <= 1'b1;
                    r_total         <= n_total;
                    if (!r_free) begin
                        r_ptr <= ptr_inc;
                    end
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_ctrl.update) begin
            r_rsp.fault       <= !r_hit;
            r_rsp.fault_count <= r_hit ? r_total : n_total;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // the scan never leaves the frames in use
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.scan |-> (CNT_W'(r_idx) < r_n))
        else $error("scan index beyond frame count");

    // oldest pointer is in range once the scan is under way
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.scan |-> (CNT_W'(r_ptr) < r_n))
        else $error("oldest pointer out of range during scan");

    // one result strobe per update, never two in a row
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // a fault always leaves a nonzero count
    a_fault_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.fault) |-> (o_rsp.fault_count != '0))
        else $error("fault reported with zero count");

    // a free frame found by the scan is always marked invalid
    a_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.update && r_free) |-> !r_valid[r_slot])
        else $error("free slot already valid");

endmodule
